// ===== hdl/slkc_pkg.sv =====
package slkc_pkg;

  localparam int DB_FRACTION_BITS = 8;
  localparam int GAIN_EXTRA_BITS = 8;

  localparam logic [21:0] DB_PER_LOG2_Q16 = 22'd394566;
  localparam logic [21:0] LOG2_PER_DB_Q24 = 22'd2786635;
  localparam logic [15:0] LEVEL_FLOOR_MAG = 16'd30720;
  localparam logic [13:0] MAKEUP_CAP = 14'd6144;
  localparam logic [15:0] METER_MAX = 16'd16383;

  localparam logic signed [14:0] THRESHOLD_RESET = -15'sd4608;
  localparam logic [15:0] SLOPE_RESET = 16'd43691;
  localparam logic [15:0] ATTACK_RESET = 16'd65399;
  localparam logic [15:0] RELEASE_RESET = 16'd65524;
  localparam logic [12:0] MAKEUP_RESET = 13'd0;
  localparam logic [12:0] KNEE_RESET = 13'd1536;

  typedef enum logic [2:0] {
    CFG_THRESHOLD,
    CFG_SLOPE,
    CFG_ATTACK,
    CFG_RELEASE,
    CFG_MAKEUP,
    CFG_AUTO_MAKEUP,
    CFG_KNEE,
    CFG_STEREO
  } cfg_index_t;

  function automatic longint unsigned isqrt64(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Successive square roots of two in Q2.30, one per fraction bit of the exponent.
  function automatic logic [15:0][30:0] root_steps();
    longint unsigned b;
    logic [15:0][30:0] res;
    b = 64'd2 << 30;
    for (int j = 0; j < 16; j++) begin
      b = isqrt64(b << 30);
      res[j] = b[30:0];
    end
    return res;
  endfunction

  localparam logic [15:0][30:0] ROOT_STEPS = root_steps();

endpackage

// ===== hdl/slkc_mul.sv =====
module slkc_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== hdl/stereo_linked_soft_knee_compressor.sv =====
// A silent input skips the log stage; other inputs pass through normalisation, one shift per
// leading zero, then the log loop, and the knee path depends on the region: nothing below the
// knee, one linear product above it, a square and a division inside it. The next input
// transfer is taken in the cycle after the result moves into the output register, so the block
// works on one sample pair at a time. The pace is set by the single shared 32x32 multiplier,
// used through the 16-step log and exp loops. Synchronous reset restores the register defaults.
module stereo_linked_soft_knee_compressor
  import slkc_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // left_in, right_in
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // left_out, right_out, reduction_level
  output logic [((2*SAMPLE_WIDTH+14+7)/8)*8-1:0] m_axis_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int OUT_W = ((2*SAMPLE_WIDTH+14+7)/8)*8;
  localparam logic [63:0] SAT_HI = (64'd1 << (SW-1)) - 64'd1;
  localparam logic [63:0] SAT_LO_MAG = 64'd1 << (SW-1);

  typedef enum logic [4:0] {
    S_IDLE, S_MAG, S_NORM, S_LOGM, S_LOGA, S_DBM, S_DBA, S_KNEE,
    S_KLIN, S_KSQ, S_KDIV0, S_KDIV, S_SMM, S_SMA, S_MKM, S_MKA,
    S_LGM, S_LGA, S_LINM, S_LINA, S_APL, S_APLA, S_APR, S_APRA, S_OUT
  } state_t;

  state_t state;

  logic signed [14:0] thr;
  logic [15:0] slope, atk, rel;
  logic [12:0] mkl, knw;
  logic amk, stereo;

  logic signed [SW-1:0] sl, sr;
  logic [31:0] nv;
  logic [4:0] e;
  logic [30:0] y;
  logic [15:0] frac;
  logic [3:0] cnt;
  logic signed [16:0] lv;
  logic [14:0] kr;
  logic [44:0] rem, dv;
  logic [12:0] q;
  logic signed [23:0] g, tot;
  logic [13:0] red;
  logic signed [4:0] ip;
  logic [15:0] fr;
  logic [30:0] lin;
  logic [SW-1:0] ol, orr;
  logic [OUT_W-1:0] out_data;
  logic out_valid;

  logic [31:0] mul_a, mul_b;
  logic [63:0] p;

  slkc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(p));

  function automatic logic [SW-1:0] gain_sat(logic [63:0] prod, logic neg, logic [5:0] sh);
    logic [63:0] rnd;
    logic [63:0] qm;
    logic [SW-1:0] res;
    rnd = prod + (64'd1 << (sh - 6'd1));
    qm = rnd >> sh;
    if (!neg) res = (qm > SAT_HI) ? SAT_HI[SW-1:0] : qm[SW-1:0];
    else if (qm > SAT_LO_MAG) res = SAT_LO_MAG[SW-1:0];
    else res = SW'(64'd0 - qm);
    return res;
  endfunction

  logic [SW-1:0] al, ar, mx;
  logic [20:0] mag16;
  logic [40:0] dbm_sum;
  logic signed [17:0] o;
  logic signed [18:0] two_o;
  logic signed [19:0] lo_sum, hi_diff;
  logic [13:0] t;
  logic [12:0] q_next;
  logic rem_ge;
  logic [31:0] klin_sum;
  logic signed [23:0] tgt;
  logic signed [24:0] diff;
  logic [23:0] absd;
  logic [15:0] coef;
  logic [16:0] kco;
  logic [39:0] dsum;
  logic [23:0] delta;
  logic [14:0] over;
  logic [30:0] mk_sum;
  logic [13:0] mk_raw;
  logic [12:0] mk;
  logic [23:0] negg, rsum;
  logic [23:0] abstot;
  logic signed [63:0] sp, pp;
  logic [61:0] lin_sum;
  logic [6:0] sh_w;

  always_comb begin
    al = sl[SW-1] ? (~sl + 1'b1) : sl;
    ar = sr[SW-1] ? (~sr + 1'b1) : sr;
    mx = (al > ar) ? al : ar;
    mag16 = {5'(SW-1), 16'd0} - {e, frac};
    dbm_sum = p[40:0] + (41'd1 << 23);
    o = {lv[16], lv} - {{3{thr[14]}}, thr};
    two_o = {o, 1'b0};
    lo_sum = {two_o[18], two_o} + {7'd0, knw};
    hi_diff = {two_o[18], two_o} - {7'd0, knw};
    t = lo_sum[13:0];
    rem_ge = rem >= dv;
    q_next = {q[11:0], rem_ge};
    klin_sum = p[31:0] + 32'd32768;
    tgt = 24'd0 - {1'b0, kr, 8'd0};
    diff = {tgt[23], tgt} - {g[23], g};
    absd = diff[24] ? 24'(25'd0 - diff) : diff[23:0];
    coef = diff[24] ? atk : rel;
    kco = 17'h10000 - {1'b0, coef};
    dsum = p[39:0] + 40'd32768;
    delta = dsum[39:16];
    over = thr[14] ? 15'(~thr + 1'b1) : 15'd0;
    mk_sum = p[30:0] + 31'd65536;
    mk_raw = amk ? mk_sum[30:17] : {1'b0, mkl};
    mk = (mk_raw > MAKEUP_CAP) ? MAKEUP_CAP[12:0] : mk_raw[12:0];
    negg = 24'd0 - g;
    rsum = negg + 24'd128;
    abstot = tot[23] ? 24'(24'd0 - tot) : tot;
    sp = tot[23] ? $signed(64'd0 - p) : $signed(p);
    pp = sp >>> 24;
    lin_sum = p[61:0] + (62'd1 << 29);
    sh_w = 7'd30 - {{2{ip[4]}}, ip};
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_LOGM: begin
        mul_a = {1'b0, y};
        mul_b = {1'b0, y};
      end
      S_DBM: begin
        mul_a = {11'd0, mag16};
        mul_b = {10'd0, DB_PER_LOG2_Q16};
      end
      S_KNEE: begin
        if (hi_diff > 0) begin
          mul_a = {16'd0, slope};
          mul_b = {17'd0, o[14:0]};
        end else begin
          mul_a = {18'd0, t};
          mul_b = {18'd0, t};
        end
      end
      S_KSQ: begin
        mul_a = {16'd0, slope};
        mul_b = {4'd0, p[27:0]};
      end
      S_SMM: begin
        mul_a = {8'd0, absd};
        mul_b = {15'd0, kco};
      end
      S_MKM: begin
        mul_a = {16'd0, slope};
        mul_b = {17'd0, over};
      end
      S_LGM: begin
        mul_a = {8'd0, abstot};
        mul_b = {10'd0, LOG2_PER_DB_Q24};
      end
      S_LINM: begin
        mul_a = {1'b0, lin};
        mul_b = {1'b0, ROOT_STEPS[cnt]};
      end
      S_APL: begin
        mul_a = 32'(al);
        mul_b = {1'b0, lin};
      end
      S_APR: begin
        mul_a = 32'(ar);
        mul_b = {1'b0, lin};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign s_axis_tready = (state == S_IDLE) && !rst;
  assign cfg_ready = !rst;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      g <= '0;
      thr <= THRESHOLD_RESET;
      slope <= SLOPE_RESET;
      atk <= ATTACK_RESET;
      rel <= RELEASE_RESET;
      mkl <= MAKEUP_RESET;
      amk <= 1'b0;
      knw <= KNEE_RESET;
      stereo <= 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_THRESHOLD: thr <= cfg_data[14:0];
          CFG_SLOPE: slope <= cfg_data;
          CFG_ATTACK: atk <= cfg_data;
          CFG_RELEASE: rel <= cfg_data;
          CFG_MAKEUP: mkl <= cfg_data[12:0];
          CFG_AUTO_MAKEUP: amk <= cfg_data[0];
          CFG_KNEE: knw <= cfg_data[12:0];
          CFG_STEREO: stereo <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && m_axis_tready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            sl <= s_axis_tdata[SW-1:0];
            sr <= stereo ? s_axis_tdata[2*SW-1:SW] : s_axis_tdata[SW-1:0];
            state <= S_MAG;
          end
        end
        S_MAG: begin
          if (mx == '0) begin
            lv <= -17'sd30720;
            state <= S_KNEE;
          end else begin
            nv <= 32'(mx) << (32 - SW);
            e <= 5'(SW - 1);
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (nv[31]) begin
            y <= nv[31:1];
            frac <= '0;
            cnt <= '0;
            state <= S_LOGM;
          end else begin
            nv <= nv << 1;
            e <= e - 5'd1;
          end
        end
        S_LOGM: state <= S_LOGA;
        S_LOGA: begin
          y <= p[61] ? p[61:31] : p[60:30];
          frac <= {frac[14:0], p[61]};
          cnt <= cnt + 4'd1;
          state <= (cnt == 4'd15) ? S_DBM : S_LOGM;
        end
        S_DBM: state <= S_DBA;
        S_DBA: begin
          if (dbm_sum[40:24] > {1'b0, LEVEL_FLOOR_MAG}) lv <= -17'sd30720;
          else lv <= 17'sd0 - $signed({1'b0, dbm_sum[39:24]});
          state <= S_KNEE;
        end
        S_KNEE: begin
          if (lo_sum < 0) begin
            kr <= '0;
            state <= S_SMM;
          end else if (hi_diff > 0) begin
            state <= S_KLIN;
          end else if (knw == '0) begin
            kr <= '0;
            state <= S_SMM;
          end else begin
            state <= S_KSQ;
          end
        end
        S_KLIN: begin
          kr <= klin_sum[30:16];
          state <= S_SMM;
        end
        S_KSQ: state <= S_KDIV0;
        S_KDIV0: begin
          rem <= p[44:0] + (45'(knw) << 18);
          dv <= 45'(knw) << 31;
          q <= '0;
          cnt <= '0;
          state <= S_KDIV;
        end
        S_KDIV: begin
          if (rem_ge) rem <= rem - dv;
          dv <= dv >> 1;
          q <= q_next;
          cnt <= cnt + 4'd1;
          if (cnt == 4'd12) begin
            kr <= {2'b00, q_next};
            state <= S_SMM;
          end
        end
        S_SMM: state <= S_SMA;
        S_SMA: begin
          g <= diff[24] ? (g - delta) : (g + delta);
          state <= S_MKM;
        end
        S_MKM: state <= S_MKA;
        S_MKA: begin
          tot <= g + {3'd0, mk, 8'd0};
          red <= ({8'd0, rsum[23:8]} > {8'd0, METER_MAX}) ? METER_MAX[13:0] : rsum[21:8];
          state <= S_LGM;
        end
        S_LGM: state <= S_LGA;
        S_LGA: begin
          fr <= pp[15:0];
          ip <= pp[20:16];
          lin <= 31'd1 << 30;
          cnt <= '0;
          state <= S_LINM;
        end
        S_LINM: state <= S_LINA;
        S_LINA: begin
          if (fr[15]) lin <= lin_sum[60:30];
          fr <= fr << 1;
          cnt <= cnt + 4'd1;
          state <= (cnt == 4'd15) ? S_APL : S_LINM;
        end
        S_APL: state <= S_APLA;
        S_APLA: begin
          ol <= gain_sat(p, sl[SW-1], sh_w[5:0]);
          state <= S_APR;
        end
        S_APR: state <= S_APRA;
        S_APRA: begin
          orr <= gain_sat(p, sr[SW-1], sh_w[5:0]);
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || m_axis_tready) begin
            out_data <= OUT_W'({red, orr, ol});
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_gain_not_positive: assert property (@(posedge clk) disable iff (rst)
    (g[23] || g == '0))
    else $error("smoothed gain above 0 dB");

  a_lin_at_least_one: assert property (@(posedge clk) disable iff (rst)
    (state == S_LINM) |-> (lin >= (31'd1 << 30)))
    else $error("linear gain fell below unity during exponent expansion");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state == S_MAG))
    else $error("accepted transfer did not start processing");

  a_result_from_final_state: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == S_OUT))
    else $error("output became valid outside the final state");
`endif

endmodule

// ===== bench/tb.sv =====
module tb
  import slkc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = 24;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [SW-1:0] left_s;
    logic [SW-1:0] right_s;
  } pair_t;

  typedef struct packed {
    logic [SW-1:0] left_s;
    logic [SW-1:0] right_s;
    logic [13:0] meter;
  } gained_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_index_t cfg_index = CFG_THRESHOLD;
  logic [15:0] cfg_data = '0;

  stereo_linked_soft_knee_compressor dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pair_t pending_pairs[$];
  gained_t expected_gains[$];
  bit idling_on = 1'b1;
  bit errors_seen = 1'b0;
  longint cycles = 0;

  longint thr_lvl, slope, attack_c, release_c, makeup_lvl, auto_mk, knee_w, stereo_on;
  longint gain_acc;

  function automatic longint level_of(longint unsigned m);
    int e;
    longint unsigned y, frac, mag16, dbm;
    longint lv;
    if (m == 0) return -(longint'(120) << 8);
    e = 0;
    while ((m >> (e + 1)) != 0) e++;
    y = m << (30 - e);
    frac = 0;
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        frac = frac | (64'd1 << (15 - i));
      end
    end
    mag16 = (64'd23 << 16) - ((longint'(e) << 16) | frac);
    dbm = (mag16 * 64'(DB_PER_LOG2_Q16) + (64'd1 << 23)) >> 24;
    lv = -longint'(dbm);
    return (lv < -(longint'(120) << 8)) ? -(longint'(120) << 8) : lv;
  endfunction

  function automatic longint knee_cut(longint o);
    longint unsigned t, num, den;
    if (2 * o < -knee_w) return 0;
    if (2 * o > knee_w) return longint'((longint'(slope * o) + 32768) >>> 16);
    if (knee_w == 0) return 0;
    t = 2 * o + knee_w;
    num = longint'(slope) * t * t;
    den = longint'(8 * knee_w) << 16;
    return longint'((num + den / 2) / den);
  endfunction

  function automatic longint round_shift16(longint v);
    if (v >= 0) return (v + 32768) >>> 16;
    return -((-v + 32768) >>> 16);
  endfunction

  function automatic logic [SW-1:0] scale_sample(longint x, longint unsigned r, longint ip);
    longint unsigned mag, qm;
    longint q, sh;
    mag = longint'(x < 0 ? -x : x) * r;
    sh = 30 - ip;
    if (sh >= 63) qm = 0;
    else qm = (mag + (64'd1 << (sh - 1))) >> sh;
    if (qm > (64'd1 << SW)) qm = 64'd1 << SW;
    q = (x < 0) ? -longint'(qm) : longint'(qm);
    if (q < -(longint'(1) << (SW - 1))) q = -(longint'(1) << (SW - 1));
    if (q > (longint'(1) << (SW - 1)) - 1) q = (longint'(1) << (SW - 1)) - 1;
    return q[SW-1:0];
  endfunction

  function automatic gained_t compress_pair(pair_t p);
    gained_t res;
    longint l, r, target, coef, red, tot, mk, pw, ip;
    longint unsigned al, ar, fr, lin, base;
    l = longint'(signed'(p.left_s));
    r = stereo_on ? longint'(signed'(p.right_s)) : l;
    al = (l < 0) ? -l : l;
    ar = (r < 0) ? -r : r;
    target = -knee_cut(level_of(al > ar ? al : ar) - thr_lvl) * 256;
    coef = (target < gain_acc) ? attack_c : release_c;
    gain_acc = gain_acc + round_shift16((65536 - coef) * (target - gain_acc));
    red = (-gain_acc + 128) >>> 8;
    if (red > 16383) red = 16383;
    if (auto_mk != 0) mk = (((thr_lvl < 0) ? -thr_lvl : 0) * slope + 65536) >>> 17;
    else mk = makeup_lvl;
    if (mk > 6144) mk = 6144;
    tot = gain_acc + mk * 256;
    pw = (tot * longint'(LOG2_PER_DB_Q24)) >>> 24;
    ip = pw >>> 16;
    fr = pw - ip * 65536;
    lin = 64'd1 << 30;
    base = 64'd2 << 30;
    for (int k = 15; k >= 0; k--) begin
      base = isqrt64(base << 30);
      if (fr[k]) lin = (lin * base + (64'd1 << 29)) >> 30;
    end
    if (ip > 30) ip = 30;
    res.left_s = scale_sample(l, lin, ip);
    res.right_s = stereo_on ? scale_sample(r, lin, ip) : res.left_s;
    res.meter = red[13:0];
    return res;
  endfunction

  always @(posedge clk) begin
    pair_t sent;
    bit go;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sent = pending_pairs.pop_front();
        expected_gains.push_back(compress_pair(sent));
      end
      go = !idling_on || ($urandom_range(0, 99) >= 16);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_pairs.size() > 0 && go) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {pending_pairs[0].right_s, pending_pairs[0].left_s};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    gained_t want;
    logic [SW-1:0] got_l, got_r;
    logic [13:0] got_m;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_l = m_axis_tdata[SW-1:0];
        got_r = m_axis_tdata[2*SW-1:SW];
        got_m = m_axis_tdata[2*SW+13:2*SW];
        if (expected_gains.size() == 0) begin
          $error("transfer with no expected result");
          errors_seen = 1'b1;
        end else begin
          want = expected_gains.pop_front();
          if (got_l !== want.left_s) begin
            $error("left_out expected %0d got %0d", signed'(want.left_s), signed'(got_l));
            errors_seen = 1'b1;
          end
          if (got_r !== want.right_s) begin
            $error("right_out expected %0d got %0d", signed'(want.right_s), signed'(got_r));
            errors_seen = 1'b1;
          end
          if (got_m !== want.meter) begin
            $error("reduction_level expected %0d got %0d", want.meter, got_m);
            errors_seen = 1'b1;
          end
        end
      end
      m_axis_tready <= !idling_on || ($urandom_range(0, 99) >= 16);
    end
  end

  task automatic write_reg(cfg_index_t idx, longint val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_THRESHOLD: thr_lvl = longint'(signed'(val[14:0]));
      CFG_SLOPE: slope = val[15:0];
      CFG_ATTACK: attack_c = val[15:0];
      CFG_RELEASE: release_c = val[15:0];
      CFG_MAKEUP: makeup_lvl = val[12:0];
      CFG_AUTO_MAKEUP: auto_mk = val[0];
      CFG_KNEE: knee_w = val[12:0];
      default: stereo_on = val[0];
    endcase
  endtask

  task automatic set_all(longint th, longint sl, longint at, longint rl, longint mk,
                         longint am, longint kn, longint st);
    write_reg(CFG_THRESHOLD, th);
    write_reg(CFG_SLOPE, sl);
    write_reg(CFG_ATTACK, at);
    write_reg(CFG_RELEASE, rl);
    write_reg(CFG_MAKEUP, mk);
    write_reg(CFG_AUTO_MAKEUP, am);
    write_reg(CFG_KNEE, kn);
    write_reg(CFG_STEREO, st);
  endtask

  function automatic logic [SW-1:0] random_sample();
    logic [SW-1:0] v;
    v = SW'($urandom);
    case ($urandom_range(0, 3))
      0: v = v;
      1: v = signed'(v) >>> $urandom_range(0, 23);
      2: v = (v >> $urandom_range(0, 23)) & {1'b0, {(SW-1){1'b1}}};
      default: v = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
    endcase
    return v;
  endfunction

  task automatic drain();
    wait (pending_pairs.size() == 0 && expected_gains.size() == 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic queue_random(int n);
    pair_t p;
    for (int i = 0; i < n; i++) begin
      p.left_s = random_sample();
      p.right_s = random_sample();
      if ($urandom_range(0, 3) == 0) p.right_s = p.left_s;
      pending_pairs.push_back(p);
    end
  endtask

  initial begin
    thr_lvl = -4608; slope = 43691; attack_c = 65399; release_c = 65524;
    makeup_lvl = 0; auto_mk = 0; knee_w = 1536; stereo_on = 1; gain_acc = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    pending_pairs.push_back('{24'h000000, 24'h000000});
    pending_pairs.push_back('{24'h7FFFFF, 24'h000000});
    pending_pairs.push_back('{24'h800000, 24'h800000});
    pending_pairs.push_back('{24'h000001, 24'hFFFFFF});
    pending_pairs.push_back('{24'h000010, 24'h7FFFFF});
    pending_pairs.push_back('{24'h7FFFFF, 24'h800000});
    pending_pairs.push_back('{24'h0FFFFF, 24'h100000});
    pending_pairs.push_back('{24'h100000, 24'hF00000});
    pending_pairs.push_back('{24'h000000, 24'h000000});
    pending_pairs.push_back('{24'h000005, 24'hFFFFFB});
    queue_random(80);
    drain();

    set_all(-12288, 62259, 0, 65535, 6144, 1, 6144, 0);
    pending_pairs.push_back('{24'h800000, 24'h000000});
    pending_pairs.push_back('{24'h7FFFFF, 24'h7FFFFF});
    pending_pairs.push_back('{24'h000001, 24'h800000});
    pending_pairs.push_back('{24'h000000, 24'h7FFFFF});
    queue_random(90);
    drain();

    set_all(0, 0, 65535, 0, 6144, 0, 0, 1);
    queue_random(90);
    drain();

    idling_on = 1'b0;
    set_all(-3000, 62259, 1000, 60000, 0, 0, 0, 1);
    queue_random(100);
    drain();
    idling_on = 1'b1;

    set_all(0, 62259, 65535, 65535, 6144, 1, 6144, 1);
    queue_random(60);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      set_all(-longint'($urandom_range(0, 12288)), $urandom_range(0, 62259),
              $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 6144), $urandom_range(0, 1),
              $urandom_range(0, 6144), $urandom_range(0, 1));
      queue_random(90);
      drain();
    end

    if (!errors_seen) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
